FILE: rtl/assert_macros.svh
// Assertion macros included by the CSR and trap unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising edge outside reset.
`define ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: rtl/rcsr_pkg.sv
// Command, status, privilege and config codes and masks for the CSR and trap unit.
`default_nettype none
package rcsr_pkg;
  localparam logic [2:0] CMD_READ = 3'd0;
  localparam logic [2:0] CMD_WRITE = 3'd1;
  localparam logic [2:0] CMD_TRAP = 3'd2;
  localparam logic [2:0] CMD_IRQ = 3'd3;
  localparam logic [2:0] CMD_SRET = 3'd4;
  localparam logic [2:0] CMD_MRET = 3'd5;
  localparam logic [2:0] CMD_SETP = 3'd6;
  localparam logic [2:0] CMD_CLRP = 3'd7;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_ILLEGAL = 2'd1;
  localparam logic [1:0] ST_XLEN = 2'd2;
  localparam logic [1:0] ST_SATP = 2'd3;

  localparam logic [1:0] PRV_U = 2'd0;
  localparam logic [1:0] PRV_S = 2'd1;
  localparam logic [1:0] PRV_M = 2'd3;

  localparam logic [0:0] CFG_HART_ID = 1'd0;
  localparam logic [0:0] CFG_ISA = 1'd1;

  localparam logic [63:0] SSTATUS_BITS = 64'hDE133;
  localparam logic [63:0] MSTATUS_BITS = 64'hE79BB;
  localparam logic [63:0] ST_FS = 64'h6000;
  localparam logic [63:0] ST_UXL = 64'h3 << 32;
  localparam logic [63:0] ST_SXL = 64'h3 << 34;
  localparam logic [2:0] COUNTER_BITS = 3'h5;

  typedef struct packed {
    logic [2:0] cmd;
    logic [11:0] csr_address;
    logic write_intent;
    logic [63:0] write_value;
    logic [5:0] trap_cause;
    logic trap_is_interrupt;
    logic [63:0] trap_value;
    logic [63:0] current_pc;
    logic [63:0] cycle_count;
  } req_t;
endpackage
`default_nettype wire

FILE: rtl/riscv_csr_trap_unit.sv
// Top level of the CSR file and trap unit: request register, state update and result register.
// A request is registered at its accepting edge and its result is registered at the
// following edge, then shows for exactly one cycle on out_valid.
// Throughput: one request per cycle; busy is always low, the single-pass update sets that rate.
// Reset (rst_n low, synchronous) clears all CSR state, sets machine privilege and widest xlen.
`default_nettype none
module riscv_csr_trap_unit import rcsr_pkg::*; #(
  parameter int REG_WIDTH = 64,
  parameter int HAS_FP = 1
) (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  output logic busy,
  input wire logic [2:0] in_cmd,
  input wire logic [11:0] in_csr_address,
  input wire logic in_write_intent,
  input wire logic [63:0] in_write_value,
  input wire logic [5:0] in_trap_cause,
  input wire logic in_trap_is_interrupt,
  input wire logic [63:0] in_trap_value,
  input wire logic [63:0] in_current_pc,
  input wire logic [63:0] in_cycle_count,
  input wire logic cfg_valid,
  output logic cfg_ready,
  input wire logic [0:0] cfg_index,
  input wire logic [25:0] cfg_data,
  output logic out_valid,
  output logic [63:0] out_read_data,
  output logic [1:0] out_status,
  output logic out_redirect,
  output logic [63:0] out_next_pc,
  output logic [1:0] out_priv_level,
  output logic [1:0] out_xlen_code
);
  localparam bit IS64 = (REG_WIDTH >= 64);
  localparam logic [63:0] WMASK = IS64 ? 64'hFFFF_FFFF_FFFF_FFFF : 64'hFFFF_FFFF;
  localparam logic [1:0] BASE = IS64 ? 2'd2 : 2'd1;
  localparam bit FP = (HAS_FP != 0);
  localparam logic [5:0] CMASK = 6'(REG_WIDTH - 1);

  logic [9:0] hart_id_r;
  logic [25:0] isa_r;
  logic req_v_r;
  req_t req_r;

  logic [63:0] sw_r, sw_nxt;
  logic [1:0] fs_r, fs_nxt, prv_r, prv_nxt, mxl_r, mxl_nxt, cxl_r, cxl_nxt;
  logic [11:0] ie_r, ie_nxt, ip_r, ip_nxt, ideleg_r, ideleg_nxt;
  logic [15:0] edeleg_r, edeleg_nxt;
  logic [63:0] stvec_r, stvec_nxt, mtvec_r, mtvec_nxt, sscr_r, sscr_nxt, mscr_r, mscr_nxt;
  logic [63:0] sepc_r, sepc_nxt, mepc_r, mepc_nxt, scause_r, scause_nxt, mcause_r, mcause_nxt;
  logic [63:0] stval_r, stval_nxt, mtval_r, mtval_nxt, satp_r, satp_nxt;
  logic [2:0] scen_r, scen_nxt, mcen_r, mcen_nxt;
  logic [4:0] ffl_r, ffl_nxt;
  logic [2:0] frm_r, frm_nxt;

  logic [63:0] rd_nxt, npc_nxt;
  logic [1:0] st_nxt;
  logic redir_nxt;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hart_id_r <= '0;
      isa_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_HART_ID: hart_id_r <= cfg_data[9:0];
        CFG_ISA: isa_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) req_v_r <= 1'b0;
    else req_v_r <= start;
    req_r <= '{in_cmd, in_csr_address, in_write_intent, in_write_value & WMASK, in_trap_cause,
               in_trap_is_interrupt, in_trap_value & WMASK, in_current_pc & WMASK,
               in_cycle_count};
  end

  function automatic logic [63:0] msb_of(input logic [1:0] xl);
    msb_of = (xl == 2'd1) ? 64'h8000_0000 : 64'h8000_0000_0000_0000;
  endfunction

  function automatic logic [63:0] st_read(input logic [63:0] sw, input logic [1:0] fs,
                                          input logic [1:0] xl, input logic [63:0] m);
    logic [63:0] r;
    r = (sw | {49'd0, fs, 13'd0}) & m;
    if (r[14:13] == 2'b11 || r[16:15] == 2'b11) r = r | msb_of(xl);
    st_read = r & WMASK;
  endfunction

  function automatic logic [1:0] fix_xl(input logic [1:0] f);
    fix_xl = (f >= 2'd1 && f <= BASE) ? f : BASE;
  endfunction

  always_comb begin
    logic [63:0] v, m, cl, vec, sw;
    logic [1:0] newp, f, mp;
    logic [11:0] pend;
    logic deleg, ill, cok, do_trap, tint, chg;
    logic [5:0] tcause;
    logic [5:0] didx;
    logic [15:0] idl;
    logic [3:0] nmode;
    logic [2:0] rm;
    logic [2:0] cen;
    logic sp;
    sw_nxt = sw_r; fs_nxt = fs_r; prv_nxt = prv_r; mxl_nxt = mxl_r; cxl_nxt = cxl_r;
    ie_nxt = ie_r; ip_nxt = ip_r; ideleg_nxt = ideleg_r; edeleg_nxt = edeleg_r;
    stvec_nxt = stvec_r; mtvec_nxt = mtvec_r; sscr_nxt = sscr_r; mscr_nxt = mscr_r;
    sepc_nxt = sepc_r; mepc_nxt = mepc_r; scause_nxt = scause_r; mcause_nxt = mcause_r;
    stval_nxt = stval_r; mtval_nxt = mtval_r; satp_nxt = satp_r;
    scen_nxt = scen_r; mcen_nxt = mcen_r; ffl_nxt = ffl_r; frm_nxt = frm_r;
    rd_nxt = '0; npc_nxt = '0; st_nxt = ST_OK; redir_nxt = 1'b0;
    v = '0; m = '0; cl = '0; vec = '0; sw = '0; newp = prv_r; f = '0; mp = '0; pend = '0;
    deleg = 1'b0; ill = 1'b0; do_trap = 1'b0; tint = 1'b0; tcause = '0; nmode = '0;
    rm = '0; sp = 1'b0; chg = 1'b0; didx = '0; idl = {4'd0, ideleg_r};
    cen = (prv_r == PRV_U) ? scen_r : mcen_r;
    cok = (prv_r == PRV_M) || cen[req_r.csr_address[1:0]];
    if (req_v_r) begin
      unique case (req_r.cmd)
        CMD_READ: begin
          if (req_r.csr_address[11:10] == 2'b11 && req_r.write_intent) ill = 1'b1;
          else if (prv_r < req_r.csr_address[9:8]) ill = 1'b1;
          else if (req_r.csr_address >= 12'h001 && req_r.csr_address <= 12'h003) begin
            if (!FP || fs_r == 2'd0) ill = 1'b1;
            else if (req_r.csr_address == 12'h001) v = {59'd0, ffl_r};
            else if (req_r.csr_address == 12'h002) v = {61'd0, frm_r};
            else v = {56'd0, frm_r, ffl_r};
          end else if (req_r.csr_address >= 12'h3A0 && req_r.csr_address <= 12'h3BF) v = '0;
          else begin
            unique case (req_r.csr_address)
              12'hC00, 12'hC02: if (!cok) ill = 1'b1; else v = req_r.cycle_count;
              12'hC80, 12'hC82:
                if (cxl_r != 2'd1 || !cok) ill = 1'b1;
                else v = {32'd0, req_r.cycle_count[63:32]};
              12'h100: v = st_read(sw_r, fs_r, cxl_r, SSTATUS_BITS | (IS64 ? ST_UXL : 64'd0));
              12'h104: v = {52'd0, ie_r & ideleg_r};
              12'h105: v = stvec_r;
              12'h106: v = {61'd0, scen_r};
              12'h140: v = sscr_r;
              12'h141: v = sepc_r;
              12'h142: v = scause_r;
              12'h143: v = stval_r;
              12'h144: v = {52'd0, ip_r & ideleg_r};
              12'h180: v = satp_r;
              12'h300: v = st_read(sw_r, fs_r, cxl_r, MSTATUS_BITS);
              12'h301: v = {38'd0, isa_r} | (cxl_r == 2'd1 ? {32'd0, mxl_r, 30'd0}
                                                        : {mxl_r, 62'd0});
              12'h302: v = {48'd0, edeleg_r};
              12'h303: v = {52'd0, ideleg_r};
              12'h304: v = {52'd0, ie_r};
              12'h305: v = mtvec_r;
              12'h306: v = {61'd0, mcen_r};
              12'h340: v = mscr_r;
              12'h341: v = mepc_r;
              12'h342: v = mcause_r;
              12'h343: v = mtval_r;
              12'h344: v = {52'd0, ip_r};
              12'hB00, 12'hB02: v = req_r.cycle_count;
              12'hB80, 12'hB82:
                if (cxl_r != 2'd1) ill = 1'b1; else v = {32'd0, req_r.cycle_count[63:32]};
              12'hF14: v = {54'd0, hart_id_r};
              default: ill = 1'b1;
            endcase
          end
          if (ill) st_nxt = ST_ILLEGAL; else rd_nxt = v & WMASK;
        end
        CMD_WRITE: begin
          v = req_r.write_value;
          if (FP && req_r.csr_address >= 12'h001 && req_r.csr_address <= 12'h003) begin
            rm = (req_r.csr_address == 12'h002) ? v[2:0] : v[7:5];
            if (req_r.csr_address != 12'h001) frm_nxt = (rm >= 3'd5) ? 3'd0 : rm;
            if (req_r.csr_address != 12'h002) ffl_nxt = v[4:0];
            fs_nxt = 2'd3;
          end else if (req_r.csr_address >= 12'h3A0 && req_r.csr_address <= 12'h3BF) begin
          end else begin
            unique case (req_r.csr_address)
              12'h100, 12'h300: begin
                if (req_r.csr_address == 12'h100) begin
                  m = SSTATUS_BITS | (IS64 ? ST_UXL : 64'd0);
                  sw = (sw_r & ~m) | (v & m);
                end else sw = v;
                fs_nxt = sw[14:13];
                m = MSTATUS_BITS & ~ST_FS;
                if (IS64 && sw[33:32] >= 2'd1 && sw[33:32] <= BASE) m = m | ST_UXL;
                if (IS64 && sw[35:34] >= 2'd1 && sw[35:34] <= BASE) m = m | ST_SXL;
                sw_nxt = ((sw_r & ~m) | (sw & m)) & WMASK;
              end
              12'h104: ie_nxt = (ie_r & ~ideleg_r) | (v[11:0] & ideleg_r);
              12'h105: stvec_nxt = v;
              12'h106: scen_nxt = v[2:0] & COUNTER_BITS;
              12'h140: sscr_nxt = v;
              12'h141: sepc_nxt = {v[63:1], 1'b0};
              12'h142: scause_nxt = v;
              12'h143: stval_nxt = v;
              12'h144: ip_nxt = (ip_r & ~ideleg_r) | (v[11:0] & ideleg_r);
              12'h180: begin
                if (IS64) begin
                  nmode = v[63:60];
                  satp_nxt = {(nmode == 4'd0 || nmode == 4'd8 || nmode == 4'd9) ? nmode
                              : satp_r[63:60], 16'd0, v[43:0]};
                end else satp_nxt = {32'd0, v[31], 9'd0, v[21:0]};
                st_nxt = ST_SATP;
              end
              12'h301: begin
                f = (cxl_r == 2'd1) ? v[31:30] : v[63:62];
                if (IS64 && f >= 2'd1 && f <= BASE && f != mxl_r) begin
                  mxl_nxt = f; cxl_nxt = f; st_nxt = ST_XLEN;
                end
              end
              12'h302: edeleg_nxt = v[15:0];
              12'h303: ideleg_nxt = (ideleg_r & ~12'h222) | (v[11:0] & 12'h222);
              12'h304: ie_nxt = (ie_r & ~12'h2AA) | (v[11:0] & 12'h2AA);
              12'h305: mtvec_nxt = v;
              12'h306: mcen_nxt = v[2:0] & COUNTER_BITS;
              12'h340: mscr_nxt = v;
              12'h341: mepc_nxt = {v[63:1], 1'b0};
              12'h342: mcause_nxt = v;
              12'h343: mtval_nxt = v;
              12'h344: ip_nxt = (ip_r & ~12'h022) | (v[11:0] & 12'h022);
              default: st_nxt = ST_ILLEGAL;
            endcase
          end
        end
        CMD_TRAP: begin
          do_trap = 1'b1; tint = req_r.trap_is_interrupt; tcause = req_r.trap_cause;
        end
        CMD_IRQ: begin
          pend = ie_r & ip_r;
          if (prv_r == PRV_M) pend = sw_r[3] ? (pend & ~ideleg_r) : 12'd0;
          else if (prv_r == PRV_S) pend = pend & (~ideleg_r | (sw_r[1] ? ideleg_r : 12'd0));
          for (int i = 11; i >= 0; i--) begin
            if (pend[i]) tcause = 6'(i);
          end
          if (pend != 12'd0) begin
            do_trap = 1'b1; tint = 1'b1;
          end
        end
        CMD_SRET: begin
          sp = sw_r[8];
          sw = sw_r;
          sw[sp] = sw_r[5];
          sw[5] = 1'b1; sw[8] = 1'b0;
          sw_nxt = sw; newp = {1'b0, sp}; chg = 1'b1;
          npc_nxt = sepc_r; redir_nxt = 1'b1;
        end
        CMD_MRET: begin
          mp = (sw_r[12:11] == 2'd2) ? 2'd0 : sw_r[12:11];
          sw = sw_r;
          sw[mp] = sw_r[7];
          sw[7] = 1'b1; sw[12:11] = 2'b00;
          sw_nxt = sw; newp = mp; chg = 1'b1;
          npc_nxt = mepc_r; redir_nxt = 1'b1;
        end
        CMD_SETP: ip_nxt = ip_r | req_r.write_value[11:0];
        CMD_CLRP: ip_nxt = ip_r & ~req_r.write_value[11:0];
        default: ;
      endcase
      if (do_trap) begin
        didx = tcause & CMASK;
        if (prv_r <= PRV_S)
          deleg = tint ? (didx[5:4] == 2'd0 && idl[didx[3:0]])
                       : (tcause[5:4] == 2'd0 && edeleg_r[tcause[3:0]]);
        cl = {58'd0, tcause} | (tint ? msb_of(cxl_r) : 64'd0);
        cl = cl & WMASK;
        sw = sw_r;
        if (deleg) begin
          scause_nxt = cl; sepc_nxt = req_r.current_pc;
          stval_nxt = (req_r.cmd == CMD_TRAP) ? req_r.trap_value : 64'd0;
          sw[5] = sw_r[prv_r]; sw[8] = prv_r[0]; sw[1] = 1'b0;
          newp = PRV_S; vec = stvec_r;
        end else begin
          mcause_nxt = cl; mepc_nxt = req_r.current_pc;
          mtval_nxt = (req_r.cmd == CMD_TRAP) ? req_r.trap_value : 64'd0;
          sw[7] = sw_r[prv_r]; sw[12:11] = prv_r; sw[3] = 1'b0;
          newp = PRV_M; vec = mtvec_r;
        end
        sw_nxt = sw; chg = 1'b1;
        if (tint && vec[1:0] != 2'd0)
          npc_nxt = ({vec[63:2], 2'b00} + {56'd0, tcause, 2'b00}) & WMASK;
        else npc_nxt = {vec[63:2], 2'b00};
        redir_nxt = 1'b1;
      end
      if (chg && newp != prv_r) begin
        prv_nxt = newp;
        if (IS64) begin
          if (newp == PRV_S) cxl_nxt = fix_xl(sw_nxt[35:34]);
          else if (newp == PRV_U) cxl_nxt = fix_xl(sw_nxt[33:32]);
          else cxl_nxt = fix_xl(mxl_r);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r <= '0; fs_r <= '0; prv_r <= PRV_M; mxl_r <= BASE; cxl_r <= BASE;
      ie_r <= '0; ip_r <= '0; ideleg_r <= '0; edeleg_r <= '0;
      stvec_r <= '0; mtvec_r <= '0; sscr_r <= '0; mscr_r <= '0;
      sepc_r <= '0; mepc_r <= '0; scause_r <= '0; mcause_r <= '0;
      stval_r <= '0; mtval_r <= '0; satp_r <= '0;
      scen_r <= '0; mcen_r <= '0; ffl_r <= '0; frm_r <= '0;
      out_valid <= 1'b0;
    end else begin
      sw_r <= sw_nxt; fs_r <= fs_nxt; prv_r <= prv_nxt; mxl_r <= mxl_nxt; cxl_r <= cxl_nxt;
      ie_r <= ie_nxt; ip_r <= ip_nxt; ideleg_r <= ideleg_nxt; edeleg_r <= edeleg_nxt;
      stvec_r <= stvec_nxt; mtvec_r <= mtvec_nxt; sscr_r <= sscr_nxt; mscr_r <= mscr_nxt;
      sepc_r <= sepc_nxt; mepc_r <= mepc_nxt; scause_r <= scause_nxt; mcause_r <= mcause_nxt;
      stval_r <= stval_nxt; mtval_r <= mtval_nxt; satp_r <= satp_nxt;
      scen_r <= scen_nxt; mcen_r <= mcen_nxt; ffl_r <= ffl_nxt; frm_r <= frm_nxt;
      out_valid <= req_v_r;
    end
    out_read_data <= rd_nxt;
    out_status <= st_nxt;
    out_redirect <= redir_nxt;
    out_next_pc <= npc_nxt;
    out_priv_level <= prv_nxt;
    out_xlen_code <= cxl_nxt;
  end

`include "assert_macros.svh"
  `ASSERT_IMP(a_priv_legal, 1'b1, prv_r != 2'd2)
  `ASSERT_IMP(a_xlen_legal, 1'b1, cxl_r >= 2'd1 && cxl_r <= BASE)
  `ASSERT_NXT(a_valid_follows, req_v_r, out_valid)
  `ASSERT_IMP(a_redirect_zero_data, out_valid && out_redirect, out_read_data == 64'd0)
endmodule
`default_nettype wire

FILE: tb/sv/riscv_csr_trap_unit_test.sv
// Self-checking testbench for the CSR and trap unit, with a built-in predictor of its state.
`default_nettype none
module riscv_csr_trap_unit_test import rcsr_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [11:0] CSR_FFLAGS = 12'h001, CSR_FRM = 12'h002, CSR_FCSR = 12'h003;
  localparam logic [11:0] CSR_PMP_LO = 12'h3A0, CSR_PMP_HI = 12'h3BF;
  localparam logic [11:0] CSR_CYCLE = 12'hC00, CSR_INSTRET = 12'hC02;
  localparam logic [11:0] CSR_CYCLEH = 12'hC80, CSR_INSTRETH = 12'hC82;
  localparam logic [11:0] CSR_MCYCLE = 12'hB00, CSR_MINSTRET = 12'hB02;
  localparam logic [11:0] CSR_MCYCLEH = 12'hB80, CSR_MINSTRETH = 12'hB82;
  localparam logic [11:0] CSR_SSTATUS = 12'h100, CSR_SIE = 12'h104, CSR_STVEC = 12'h105;
  localparam logic [11:0] CSR_SCOUNTEREN = 12'h106, CSR_SSCRATCH = 12'h140;
  localparam logic [11:0] CSR_SEPC = 12'h141, CSR_SCAUSE = 12'h142, CSR_STVAL = 12'h143;
  localparam logic [11:0] CSR_SIP = 12'h144, CSR_SATP = 12'h180;
  localparam logic [11:0] CSR_MSTATUS = 12'h300, CSR_MISA = 12'h301, CSR_MEDELEG = 12'h302;
  localparam logic [11:0] CSR_MIDELEG = 12'h303, CSR_MIE = 12'h304, CSR_MTVEC = 12'h305;
  localparam logic [11:0] CSR_MCOUNTEREN = 12'h306, CSR_MSCRATCH = 12'h340;
  localparam logic [11:0] CSR_MEPC = 12'h341, CSR_MCAUSE = 12'h342, CSR_MTVAL = 12'h343;
  localparam logic [11:0] CSR_MIP = 12'h344, CSR_MHARTID = 12'hF14, CSR_UNKNOWN = 12'h7C0;
  localparam logic [63:0] ST_SIE = 64'h2, ST_MIE = 64'h8, ST_SPIE = 64'h20, ST_MPIE = 64'h80;
  localparam logic [63:0] ST_SPP = 64'h100, ST_MPP = 64'h1800, ST_XS = 64'h18000;
  localparam logic [11:0] PEND_BITS = 12'hFFF;

  typedef struct packed {
    logic [63:0] read_data;
    logic [1:0] status;
    logic redirect;
    logic [63:0] next_pc;
    logic [1:0] priv_level;
    logic [1:0] xlen_code;
  } csr_result_t;

  logic clk = 1'b0, rst_n = 1'b0, start = 1'b0, busy;
  logic [2:0] in_cmd = '0;
  logic [11:0] in_csr_address = '0;
  logic in_write_intent = 1'b0, in_trap_is_interrupt = 1'b0;
  logic [63:0] in_write_value = '0, in_trap_value = '0, in_current_pc = '0, in_cycle_count = '0;
  logic [5:0] in_trap_cause = '0;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [0:0] cfg_index = '0;
  logic [25:0] cfg_data = '0;
  logic out_valid, out_redirect;
  logic [63:0] out_read_data, out_next_pc;
  logic [1:0] out_status, out_priv_level, out_xlen_code;

  riscv_csr_trap_unit i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted architectural state.
  logic [63:0] mst, stvec, mtvec, sscratch, mscratch, sepc, mepc, scause, mcause;
  logic [63:0] stval, mtval, satp;
  logic [1:0] fs, prv, mxl, cxl;
  logic [11:0] mie, mip, mideleg;
  logic [15:0] medeleg;
  logic [2:0] scen, mcen, frm;
  logic [4:0] fflags;
  logic [9:0] hart_id;
  logic [25:0] isa_ext;

  req_t pending_reqs[$];
  csr_result_t expected_results[$];
  int unsigned wait_cycles = 0, errors = 0, n_items = 0, n_illegal = 0, n_redirect = 0;
  int unsigned n_xlen32 = 0, n_cfg = 0;
  logic accepted = 1'b0;

  function automatic int unsigned xbits();
    return cxl == 2'd1 ? 32 : 64;
  endfunction

  function automatic void arch_reset();
    mst = '0; stvec = '0; mtvec = '0; sscratch = '0; mscratch = '0; sepc = '0; mepc = '0;
    scause = '0; mcause = '0; stval = '0; mtval = '0; satp = '0;
    fs = '0; prv = PRV_M; mxl = 2'd2; cxl = 2'd2;
    mie = '0; mip = '0; mideleg = '0; medeleg = '0;
    scen = '0; mcen = '0; frm = '0; fflags = '0; hart_id = '0; isa_ext = '0;
  endfunction

  function automatic logic [63:0] status_view(input logic [63:0] mask);
    logic [63:0] r;
    r = (mst | ({62'b0, fs} << 13)) & mask;
    if ((r & ST_FS) == ST_FS || (r & ST_XS) == ST_XS) r |= 64'd1 << (xbits() - 1);
    return r;
  endfunction

  function automatic void status_update(input logic [63:0] v);
    logic [63:0] m;
    m = MSTATUS_BITS & ~ST_FS;
    fs = v[14:13];
    if (v[33:32] == 2'd1 || v[33:32] == 2'd2) m |= ST_UXL;
    if (v[35:34] == 2'd1 || v[35:34] == 2'd2) m |= ST_SXL;
    mst = (mst & ~m) | (v & m);
  endfunction

  function automatic void change_priv(input logic [1:0] p);
    logic [1:0] f;
    if (prv == p) return;
    f = p == PRV_S ? mst[35:34] : p == PRV_U ? mst[33:32] : mxl;
    if (f < 2'd1 || f > 2'd2) f = 2'd2;
    cxl = f;
    prv = p;
  endfunction

  function automatic logic counter_allowed(input logic [11:0] a);
    logic [2:0] en;
    if (prv == PRV_M) return 1'b1;
    en = prv == PRV_U ? scen : mcen;
    return en[a[1:0]];
  endfunction

  function automatic logic [1:0] csr_fetch(input logic [11:0] a, input logic ww,
                                           input logic [63:0] cyc, output logic [63:0] val);
    logic [63:0] v;
    val = '0;
    v = '0;
    if (a[11:10] == 2'b11 && ww) return ST_ILLEGAL;
    if (prv < a[9:8]) return ST_ILLEGAL;
    if (a >= CSR_FFLAGS && a <= CSR_FCSR) begin
      if (fs == 2'd0) return ST_ILLEGAL;
      v = a == CSR_FFLAGS ? {59'b0, fflags} : a == CSR_FRM ? {61'b0, frm} : {56'b0, frm, fflags};
    end else if (a >= CSR_PMP_LO && a <= CSR_PMP_HI) begin
      v = '0;
    end else begin
      case (a)
        CSR_CYCLE, CSR_INSTRET: begin
          if (!counter_allowed(a)) return ST_ILLEGAL;
          v = cyc;
        end
        CSR_CYCLEH, CSR_INSTRETH: begin
          if (cxl != 2'd1 || !counter_allowed(a)) return ST_ILLEGAL;
          v = cyc >> 32;
        end
        CSR_SSTATUS: v = status_view(SSTATUS_BITS | ST_UXL);
        CSR_SIE: v = {52'b0, mie & mideleg};
        CSR_STVEC: v = stvec;
        CSR_SCOUNTEREN: v = {61'b0, scen};
        CSR_SSCRATCH: v = sscratch;
        CSR_SEPC: v = sepc;
        CSR_SCAUSE: v = scause;
        CSR_STVAL: v = stval;
        CSR_SIP: v = {52'b0, mip & mideleg};
        CSR_SATP: v = satp;
        CSR_MSTATUS: v = status_view(MSTATUS_BITS);
        CSR_MISA: v = {38'b0, isa_ext} | ({62'b0, mxl} << (xbits() - 2));
        CSR_MEDELEG: v = {48'b0, medeleg};
        CSR_MIDELEG: v = {52'b0, mideleg};
        CSR_MIE: v = {52'b0, mie};
        CSR_MTVEC: v = mtvec;
        CSR_MCOUNTEREN: v = {61'b0, mcen};
        CSR_MSCRATCH: v = mscratch;
        CSR_MEPC: v = mepc;
        CSR_MCAUSE: v = mcause;
        CSR_MTVAL: v = mtval;
        CSR_MIP: v = {52'b0, mip};
        CSR_MCYCLE, CSR_MINSTRET: v = cyc;
        CSR_MCYCLEH, CSR_MINSTRETH: begin
          if (cxl != 2'd1) return ST_ILLEGAL;
          v = cyc >> 32;
        end
        CSR_MHARTID: v = {54'b0, hart_id};
        default: return ST_ILLEGAL;
      endcase
    end
    val = v;
    return ST_OK;
  endfunction

  function automatic logic [1:0] csr_store(input logic [11:0] a, input logic [63:0] v);
    logic [63:0] m;
    logic [3:0] mode;
    logic [1:0] nm;
    if (a >= CSR_FFLAGS && a <= CSR_FCSR) begin
      if (a != CSR_FFLAGS) begin
        frm = a == CSR_FRM ? v[2:0] : v[7:5];
        if (frm >= 3'd5) frm = 3'd0;
      end
      if (a != CSR_FRM) fflags = v[4:0];
      fs = 2'd3;
      return ST_OK;
    end
    if (a >= CSR_PMP_LO && a <= CSR_PMP_HI) return ST_OK;
    case (a)
      CSR_SSTATUS: begin
        m = SSTATUS_BITS | ST_UXL;
        status_update((mst & ~m) | (v & m));
      end
      CSR_SIE: mie = (mie & ~mideleg) | (v[11:0] & mideleg);
      CSR_STVEC: stvec = v;
      CSR_SCOUNTEREN: scen = v[2:0] & COUNTER_BITS;
      CSR_SSCRATCH: sscratch = v;
      CSR_SEPC: sepc = v & ~64'd1;
      CSR_SCAUSE: scause = v;
      CSR_STVAL: stval = v;
      CSR_SIP: mip = (mip & ~mideleg) | (v[11:0] & mideleg);
      CSR_SATP: begin
        mode = satp[63:60];
        if (v[63:60] == 4'd0 || v[63:60] == 4'd8 || v[63:60] == 4'd9) mode = v[63:60];
        satp = {mode, 16'b0, v[43:0]};
        return ST_SATP;
      end
      CSR_MSTATUS: status_update(v);
      CSR_MISA: begin
        nm = 2'(v >> (xbits() - 2));
        if ((nm == 2'd1 || nm == 2'd2) && nm != mxl) begin
          mxl = nm;
          cxl = nm;
          return ST_XLEN;
        end
      end
      CSR_MEDELEG: medeleg = v[15:0];
      CSR_MIDELEG: mideleg = (mideleg & ~12'h222) | (v[11:0] & 12'h222);
      CSR_MIE: mie = (mie & ~12'h2AA) | (v[11:0] & 12'h2AA);
      CSR_MTVEC: mtvec = v;
      CSR_MCOUNTEREN: mcen = v[2:0] & COUNTER_BITS;
      CSR_MSCRATCH: mscratch = v;
      CSR_MEPC: mepc = v & ~64'd1;
      CSR_MCAUSE: mcause = v;
      CSR_MTVAL: mtval = v;
      CSR_MIP: mip = (mip & ~12'h022) | (v[11:0] & 12'h022);
      default: return ST_ILLEGAL;
    endcase
    return ST_OK;
  endfunction

  function automatic logic [63:0] enter_trap(input logic [5:0] cause, input logic is_int,
                                             input logic [63:0] tval, input logic [63:0] pc);
    logic deleg;
    logic [63:0] cl, vec;
    logic [1:0] p;
    p = prv;
    deleg = 1'b0;
    if (p <= PRV_S)
      deleg = is_int ? (({52'b0, mideleg} >> cause) & 64'd1) != 0
                     : (({48'b0, medeleg} >> cause) & 64'd1) != 0;
    cl = {58'b0, cause};
    if (is_int) cl |= 64'd1 << (xbits() - 1);
    if (deleg) begin
      scause = cl; sepc = pc; stval = tval;
      mst = (mst & ~ST_SPIE) | (((mst >> p) & 64'd1) << 5);
      mst = (mst & ~ST_SPP) | ({63'b0, p[0]} << 8);
      mst &= ~ST_SIE;
      change_priv(PRV_S);
      vec = stvec;
    end else begin
      mcause = cl; mepc = pc; mtval = tval;
      mst = (mst & ~ST_MPIE) | (((mst >> p) & 64'd1) << 7);
      mst = (mst & ~ST_MPP) | ({62'b0, p} << 11);
      mst &= ~ST_MIE;
      change_priv(PRV_M);
      vec = mtvec;
    end
    if (is_int && vec[1:0] != 2'd0) return (vec & ~64'd3) + {56'b0, cause, 2'b0};
    return vec & ~64'd3;
  endfunction

  function automatic csr_result_t predict_result(input req_t r);
    csr_result_t o;
    logic [11:0] pend;
    logic [1:0] p;
    o = '0;
    case (r.cmd)
      CMD_READ: o.status = csr_fetch(r.csr_address, r.write_intent, r.cycle_count, o.read_data);
      CMD_WRITE: o.status = csr_store(r.csr_address, r.write_value);
      CMD_TRAP: begin
        o.next_pc = enter_trap(r.trap_cause, r.trap_is_interrupt, r.trap_value, r.current_pc);
        o.redirect = 1'b1;
      end
      CMD_IRQ: begin
        pend = mie & mip;
        if (prv == PRV_M) pend &= mst[3] ? ~mideleg : 12'b0;
        else if (prv == PRV_S) pend &= ~mideleg | (mst[1] ? mideleg : 12'b0);
        for (int i = 0; i < 12; i++) begin
          if (pend[i] && !o.redirect) begin
            o.next_pc = enter_trap(6'(i), 1'b1, '0, r.current_pc);
            o.redirect = 1'b1;
          end
        end
      end
      CMD_SRET: begin
        p = {1'b0, mst[8]};
        mst[p] = mst[5];
        mst = (mst | ST_SPIE) & ~ST_SPP;
        change_priv(p);
        o.next_pc = sepc;
        o.redirect = 1'b1;
      end
      CMD_MRET: begin
        p = mst[12:11];
        if (p == 2'd2) p = PRV_U;
        mst[p] = mst[7];
        mst = (mst | ST_MPIE) & ~ST_MPP;
        change_priv(p);
        o.next_pc = mepc;
        o.redirect = 1'b1;
      end
      CMD_SETP: mip = (mip | r.write_value[11:0]) & PEND_BITS;
      default: mip &= ~r.write_value[11:0] & PEND_BITS;
    endcase
    o.priv_level = prv;
    o.xlen_code = cxl;
    return o;
  endfunction

  function automatic logic [11:0] pick_csr();
    logic [11:0] known [0:37];
    known = '{CSR_FFLAGS, CSR_FRM, CSR_FCSR, CSR_PMP_LO, CSR_PMP_HI, CSR_CYCLE, CSR_INSTRET,
              CSR_CYCLEH, CSR_INSTRETH, CSR_MCYCLE, CSR_MINSTRET, CSR_MCYCLEH, CSR_MINSTRETH,
              CSR_SSTATUS, CSR_SIE, CSR_STVEC, CSR_SCOUNTEREN, CSR_SSCRATCH, CSR_SEPC,
              CSR_SCAUSE, CSR_STVAL, CSR_SIP, CSR_SATP, CSR_MSTATUS, CSR_MISA, CSR_MEDELEG,
              CSR_MIDELEG, CSR_MIE, CSR_MTVEC, CSR_MCOUNTEREN, CSR_MSCRATCH, CSR_MEPC,
              CSR_MCAUSE, CSR_MTVAL, CSR_MIP, CSR_MHARTID, CSR_MSTATUS, CSR_MIE};
    if ($urandom_range(9) == 0) return 12'($urandom);
    return known[$urandom_range(37)];
  endfunction

  function automatic logic [63:0] rand64();
    case ($urandom_range(3))
      0: return {$urandom, $urandom};
      1: return {32'b0, $urandom};
      2: return {60'b0, 4'($urandom)};
      default: return ~64'($urandom_range(15));
    endcase
  endfunction

  function automatic req_t make_req(input logic [2:0] c, input logic [11:0] a,
                                    input logic [63:0] wv);
    req_t r;
    r.cmd = c;
    r.csr_address = a;
    r.write_intent = 1'($urandom);
    r.write_value = wv;
    r.trap_cause = 6'($urandom);
    r.trap_is_interrupt = 1'($urandom);
    r.trap_value = {$urandom, $urandom};
    r.current_pc = {$urandom, $urandom};
    r.cycle_count = {$urandom, $urandom};
    return r;
  endfunction

  function automatic req_t random_req();
    int unsigned w;
    logic [2:0] c;
    w = $urandom_range(99);
    c = w < 34 ? CMD_READ : w < 66 ? CMD_WRITE : w < 76 ? CMD_TRAP : w < 84 ? CMD_IRQ :
        w < 88 ? CMD_SRET : w < 94 ? CMD_MRET : w < 97 ? CMD_SETP : CMD_CLRP;
    return make_req(c, pick_csr(), rand64());
  endfunction

  function automatic int unsigned draw_gap();
    return $urandom_range(1) ? 0 : $urandom_range(17);
  endfunction

  // Request driver: inputs change on the falling edge.
  always @(negedge clk) begin
    if (rst_n && (!start || accepted)) begin
      if (wait_cycles > 0) begin
        start <= 1'b0;
        wait_cycles <= wait_cycles - 1;
      end else if (pending_reqs.size() > 0) begin
        req_t r;
        r = pending_reqs.pop_front();
        in_cmd <= r.cmd;
        in_csr_address <= r.csr_address;
        in_write_intent <= r.write_intent;
        in_write_value <= r.write_value;
        in_trap_cause <= r.trap_cause;
        in_trap_is_interrupt <= r.trap_is_interrupt;
        in_trap_value <= r.trap_value;
        in_current_pc <= r.current_pc;
        in_cycle_count <= r.cycle_count;
        start <= 1'b1;
        wait_cycles <= draw_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Result monitor and request predictor: sampled on the rising edge.
  always @(posedge clk) begin
    csr_result_t got, exp_r;
    req_t r;
    accepted <= rst_n && start && !busy;
    if (rst_n && out_valid) begin
      got = '{out_read_data, out_status, out_redirect, out_next_pc, out_priv_level,
              out_xlen_code};
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
      end else begin
        exp_r = expected_results.pop_front();
        if (got !== exp_r) begin
          errors++;
          if (errors <= 10) $display("result differs: expected %p, got %p", exp_r, got);
        end
      end
    end
    if (rst_n && start && !busy) begin
      r = '{in_cmd, in_csr_address, in_write_intent, in_write_value, in_trap_cause,
            in_trap_is_interrupt, in_trap_value, in_current_pc, in_cycle_count};
      exp_r = predict_result(r);
      expected_results.push_back(exp_r);
      n_items++;
      if (exp_r.status == ST_ILLEGAL) n_illegal++;
      if (exp_r.redirect) n_redirect++;
      if (exp_r.xlen_code == 2'd1) n_xlen32++;
    end
  end

  task automatic settle();
    while (pending_reqs.size() > 0 || start || expected_results.size() > 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_config(input logic [0:0] idx, input logic [25:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_HART_ID) hart_id = d[9:0];
    else isa_ext = d;
    n_cfg++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_directed();
    pending_reqs.push_back(make_req(CMD_READ, CSR_FFLAGS, '0));
    pending_reqs.push_back(make_req(CMD_WRITE, CSR_MSTATUS, '1));
    pending_reqs.push_back(make_req(CMD_READ, CSR_MSTATUS, '0));
    pending_reqs.push_back(make_req(CMD_READ, CSR_SSTATUS, '0));
    pending_reqs.push_back(make_req(CMD_WRITE, CSR_FCSR, '1));
    pending_reqs.push_back(make_req(CMD_READ, CSR_FCSR, '0));
    pending_reqs.push_back(make_req(CMD_WRITE, CSR_FRM, 64'd6));
    pending_reqs.push_back(make_req(CMD_READ, CSR_FRM, '0));
    pending_reqs.push_back(make_req(CMD_READ, CSR_UNKNOWN, '0));
    pending_reqs.push_back(make_req(CMD_WRITE, CSR_UNKNOWN, '1));
    pending_reqs.push_back(make_req(CMD_WRITE, CSR_SATP, '1));
    pending_reqs.push_back(make_req(CMD_WRITE, CSR_SATP, 64'h9000_0000_0000_0000));
    pending_reqs.push_back(make_req(CMD_WRITE, CSR_PMP_HI, '1));
    pending_reqs.push_back(make_req(CMD_READ, CSR_MHARTID, '0));
    pending_reqs.push_back(make_req(CMD_WRITE, CSR_MTVEC, 64'h8000_0001));
    pending_reqs.push_back(make_req(CMD_WRITE, CSR_MIE, '1));
    pending_reqs.push_back(make_req(CMD_SETP, CSR_MIP, '1));
    pending_reqs.push_back(make_req(CMD_IRQ, CSR_MIP, '0));
    pending_reqs.push_back(make_req(CMD_MRET, CSR_MEPC, '0));
    pending_reqs.push_back(make_req(CMD_READ, CSR_CYCLE, '0));
    pending_reqs.push_back(make_req(CMD_TRAP, CSR_MCAUSE, '0));
    pending_reqs.push_back(make_req(CMD_SRET, CSR_SEPC, '0));
    pending_reqs.push_back(make_req(CMD_CLRP, CSR_MIP, '1));
    pending_reqs.push_back(make_req(CMD_WRITE, CSR_MISA, 64'h4000_0000_0000_0000));
    pending_reqs.push_back(make_req(CMD_READ, CSR_CYCLEH, '0));
    pending_reqs.push_back(make_req(CMD_WRITE, CSR_MISA, 64'h8000_0000));
  endtask

  initial begin
    arch_reset();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    write_config(CFG_HART_ID, 26'h3FF);
    write_config(CFG_ISA, 26'h3FF_FFFF);
    push_directed();
    settle();
    for (int ph = 0; ph < 4; ph++) begin
      if (ph == 1) begin
        write_config(CFG_HART_ID, '0);
        write_config(CFG_ISA, '0);
      end else if (ph > 1) begin
        write_config(CFG_HART_ID, 26'($urandom_range(1023)));
        write_config(CFG_ISA, 26'($urandom));
      end
      repeat (320) pending_reqs.push_back(random_req());
      settle();
    end
    $display("%0d requests checked with %0d config writes: %0d illegal, %0d redirects,",
             n_items, n_cfg, n_illegal, n_redirect);
    $display("%0d results in 32-bit mode, %0d mismatches", n_xlen32, errors);
    if (errors == 0) begin
      $display("riscv_csr_trap_unit: match");
    end else begin
      $display("riscv_csr_trap_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("riscv_csr_trap_unit: mismatch");
    $finish;
  end
endmodule
`default_nettype wire

FILE: sim.f
+incdir+rtl
rtl/rcsr_pkg.sv
rtl/riscv_csr_trap_unit.sv
tb/sv/riscv_csr_trap_unit_test.sv
